// ----- sv/rth_pkg.sv -----
// ----------------------------------------------------------------------------
// rth_pkg: shared types and the divider step for the RGB to HSV converter
// Holds the divider lane record, the pipeline record that travels between
// stages, and one shift-compare-subtract step of the restoring divider.
// ----------------------------------------------------------------------------
package rth_pkg;

  // One lane of the restoring divider. The remainder always stays below the
  // divisor, and the low numerator bits are shifted in one at a time.
  typedef struct packed {
    logic [8:0] den;
    logic [8:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } div_lane_t;

  // Everything one pixel carries through the divider stages.
  typedef struct packed {
    div_lane_t  hue;
    div_lane_t  sat;
    logic [7:0] val;
    logic       flat;
  } pix_t;

  // One quotient bit: bring in the next numerator bit, subtract if it fits.
  function automatic div_lane_t div_step(input div_lane_t a);
    logic [9:0] trial;
    div_lane_t  r;
    r     = a;
    trial = {a.rem, a.low[7]};
    r.low = {a.low[6:0], 1'b0};
    if (trial >= {1'b0, a.den}) begin
      r.rem = 9'(trial - {1'b0, a.den});
      r.quo = {a.quo[6:0], 1'b1};
    end else begin
      r.rem = trial[8:0];
      r.quo = {a.quo[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- sv/rth_front.sv -----
// ----------------------------------------------------------------------------
// rth_front: extremes, hue offset and dividend preparation
// Two register stages: the first finds max, min and the dominant channel, the
// second forms the hue and saturation dividends and divisors.
// ----------------------------------------------------------------------------
module rth_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  output logic          out_valid,
  output rth_pkg::pix_t out_pix
);
  import rth_pkg::*;

  typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} sel_t;

  // Stage A registers.
  logic       a_valid;
  logic [7:0] a_r, a_g, a_b, a_mx, a_mn;
  sel_t       a_sel;

  logic [7:0] mx_next, mn_next;
  sel_t       sel_next;

  always_comb begin
    // Red wins ties, then green.
    if (red >= green && red >= blue) begin
      sel_next = SEL_RED;
      mx_next  = red;
    end else if (green >= blue) begin
      sel_next = SEL_GREEN;
      mx_next  = green;
    end else begin
      sel_next = SEL_BLUE;
      mx_next  = blue;
    end
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_r   <= red;
      a_g   <= green;
      a_b   <= blue;
      a_mx  <= mx_next;
      a_mn  <= mn_next;
      a_sel <= sel_next;
    end
  end

  // Stage B: offset into the hue circle and the two dividends.
  logic [7:0]  d;
  logic [10:0] x;
  logic [16:0] num_h;
  logic [15:0] num_s;
  pix_t        pix_next;

  always_comb begin
    d = a_mx - a_mn;
    unique case (a_sel)
      SEL_RED: begin
        // A negative offset wraps once around the circle (6d).
        x = ((a_g >= a_b) ? 11'd0 : ({2'b0, d, 1'b0} + {1'b0, d, 2'b0}))
            + 11'(a_g) - 11'(a_b);
      end
      SEL_GREEN: x = 11'({d, 1'b0}) + 11'(a_b) - 11'(a_r);
      SEL_BLUE:  x = 11'({d, 2'b0}) + 11'(a_r) - 11'(a_g);
      default:   x = 11'd0;
    endcase
    num_h = {x, 6'b0} + {2'b0, x, 4'b0} + {4'b0, x, 2'b0} + {6'b0, x};
    num_s = {d, 8'b0} - {8'b0, d};

    pix_next.hue.den = {d, 1'b0};
    pix_next.hue.rem = num_h[16:8];
    pix_next.hue.low = num_h[7:0];
    pix_next.hue.quo = 8'd0;
    pix_next.sat.den = {1'b0, a_mx};
    pix_next.sat.rem = {1'b0, num_s[15:8]};
    pix_next.sat.low = num_s[7:0];
    pix_next.sat.quo = 8'd0;
    pix_next.val     = a_mx;
    pix_next.flat    = (d == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
    if (en) begin
      out_pix <= pix_next;
    end
  end

endmodule

// ----- sv/rth_div_stage.sv -----
// ----------------------------------------------------------------------------
// rth_div_stage: two quotient bits of both divisions
// Runs two restoring-division steps on the hue and saturation lanes and
// registers the result.
// ----------------------------------------------------------------------------
module rth_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  rth_pkg::pix_t in_pix,
  output logic          out_valid,
  output rth_pkg::pix_t out_pix
);
  import rth_pkg::*;

  pix_t pix_next;

  always_comb begin
    pix_next     = in_pix;
    pix_next.hue = div_step(div_step(in_pix.hue));
    pix_next.sat = div_step(div_step(in_pix.sat));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_pix <= pix_next;
    end
  end

endmodule

// ----- sv/rgb_to_hsv_8bit.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit: pipelined 8-bit RGB to HSV converter
// Converts one pixel per clock, while the receiver does not stall, to hue,
// saturation and value with exact integer floors.
// ----------------------------------------------------------------------------
// Usage:
// A request on the pixel channel (pix_valid, pix_stall, red_in, green_in,
// blue_in) carries one RGB pixel. Each pixel yields exactly one request on
// the result channel (hsv_valid, hsv_stall, hue_out, sat_out, val_out), in
// order.
// From acceptance to hsv_valid, the extremes register loads at the accepting
// edge, then one stage forms the dividends, four run the two restoring
// dividers at two quotient bits each, and the output register holds the
// result.
// Throughput is one pixel per clock while the pipeline is not stalled; the
// eight-bit quotients set the divider depth.
// When the receiver stalls while a result is held, the whole pipeline
// freezes and pix_stall rises, so nothing is dropped or repeated; bubbles
// move forward freely whenever the output register is empty or taken.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       hsv_valid,
  input  logic       hsv_stall,
  output logic [7:0] hue_out,
  output logic [7:0] sat_out,
  output logic [7:0] val_out
);
  import rth_pkg::*;

  // The pipeline advances unless a held result is being stalled.
  logic en;
  assign en        = !(hsv_valid && hsv_stall);
  assign pix_stall = !en;

  logic front_valid;
  pix_t front_pix;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pix_valid),
    .red       (red_in),
    .green     (green_in),
    .blue      (blue_in),
    .out_valid (front_valid),
    .out_pix   (front_pix)
  );

  // Four divider stages, two quotient bits each.
  logic [4:0] stg_valid;
  pix_t       stg_pix [5];

  assign stg_valid[0] = front_valid;
  assign stg_pix[0]   = front_pix;

  for (genvar i = 0; i < 4; i++) begin : g_div
    rth_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[i]),
      .in_pix    (stg_pix[i]),
      .out_valid (stg_valid[i+1]),
      .out_pix   (stg_pix[i+1])
    );
  end

  // Output register. A grey or black pixel forces hue and saturation to
  // zero, which also covers the divide-by-zero lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en) begin
      hsv_valid <= stg_valid[4];
    end
    if (en) begin
      hue_out <= stg_pix[4].flat ? 8'd0 : stg_pix[4].hue.quo;
      sat_out <= stg_pix[4].flat ? 8'd0 : stg_pix[4].sat.quo;
      val_out <= stg_pix[4].val;
    end
  end

endmodule
